FILE: hw/rtl/rhca_pkg.sv
// Shared types, constants and cell arithmetic for the ring hue automaton.
package rhca_pkg;

  localparam int unsigned FACES       = 4;
  localparam int unsigned HUE_W       = 8;
  localparam int unsigned FACE_STRIDE = 64;
  localparam int unsigned RING_STRIDE = 15;
  localparam int unsigned RING_IDX_W  = 5;

  localparam logic CFG_STEP_PERIOD   = 1'b0;
  localparam logic CFG_HUE_INCREMENT = 1'b1;

  localparam logic [HUE_W-1:0] STEP_PERIOD_RST   = 8'd2;
  localparam logic [HUE_W-1:0] HUE_INCREMENT_RST = 8'd3;

  typedef logic [HUE_W-1:0] hue_t;
  typedef logic [FACES-1:0][HUE_W-1:0] ring_t;

  typedef struct packed {
    logic step;
    logic rotate;
  } cell_ctrl_t;

  function automatic ring_t ring_reset(int unsigned ring);
    ring_t val;
    for (int unsigned f = 0; f < FACES; f++) begin
      val[f] = HUE_W'((f * FACE_STRIDE + ring * RING_STRIDE) % 256);
    end
    return val;
  endfunction

  function automatic hue_t cell_mix(hue_t me, hue_t bk, hue_t lf, hue_t rt);
    logic [10:0] mix;
    logic [8:0]  sum;
    mix = (11'(bk) << 2) + (11'(me) << 1) + 11'(lf) + 11'(rt);
    sum = 9'(me) + 9'(mix >> 3);
    return sum[8:1];
  endfunction

endpackage

FILE: hw/rtl/ring_hue_cellular_automaton.sv
// Top level of the ring hue automaton: tick counter, cell chain, result sequencing.
// A stepping tick updates all rings at its accept edge; ring 0 shows the result in the next cycle.
// Results: a stepping tick sends RINGS results, one per cycle while out_ready_i is high, as the ring
//   chain rotates by one cell; a tick that does not step sends no results and leaves the input ready.
// Input is held off while results of a step are being sent.
// Reset: cells return to face*64 + ring*15, global hue and tick count clear, registers
//   return to step period 2 and hue increment 3.
module ring_hue_cellular_automaton
  import rhca_pkg::*;
#(
  parameter int unsigned RINGS = 18
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [HUE_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  frame_tick_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [RING_IDX_W-1:0] ring_index_o,
  output logic [HUE_W-1:0]      hue_top_o,
  output logic [HUE_W-1:0]      hue_right_o,
  output logic [HUE_W-1:0]      hue_bottom_o,
  output logic [HUE_W-1:0]      hue_left_o,
  output logic                  last_ring_o
);

  localparam int unsigned CNT_W = $clog2(RINGS);

  logic [HUE_W-1:0] period_q, incr_q;
  logic [HUE_W-1:0] tick_q, tick_d, tick_inc;
  logic [HUE_W-1:0] ghue_q, ghue_d;
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_acc, out_acc, step_hit, is_last;
  ring_t            inject;
  cell_ctrl_t       ctrl;
  ring_t            ring_hue [RINGS];

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o && frame_tick_i;
  assign out_acc    = out_valid_o && out_ready_i;
  assign tick_inc   = tick_q + 8'd1;
  assign step_hit   = !(tick_inc < period_q);
  assign is_last    = (cnt_q == CNT_W'(RINGS - 1));

  assign ghue_d = ghue_q + incr_q;
  always_comb begin
    for (int unsigned f = 0; f < FACES; f++) begin
      inject[f] = ghue_d + HUE_W'(f * FACE_STRIDE);
    end
  end

  assign ctrl.step   = in_acc && step_hit;
  assign ctrl.rotate = out_acc;

  always_comb begin
    tick_d = tick_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (in_acc) begin
      tick_d = step_hit ? '0 : tick_inc;
    end
    if (ctrl.step) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (out_acc) begin
      if (is_last) begin
        busy_d = 1'b0;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= STEP_PERIOD_RST;
      incr_q   <= HUE_INCREMENT_RST;
      tick_q   <= '0;
      ghue_q   <= '0;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_STEP_PERIOD:   period_q <= cfg_data_i;
          CFG_HUE_INCREMENT: incr_q   <= cfg_data_i;
          default:           period_q <= period_q;
        endcase
      end
      if (ctrl.step) begin
        ghue_q <= ghue_d;
      end
      tick_q <= tick_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  for (genvar r = 0; r < RINGS; r++) begin : g_ring
    if (r == RINGS - 1) begin : g_far
      rhca_cell #(.RING_ID(r), .FAR(1'b1)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .back_i (inject),
        .next_i (ring_hue[0]),
        .hue_o  (ring_hue[r])
      );
    end else if (r == RINGS - 2) begin : g_near_far
      rhca_cell #(.RING_ID(r), .FAR(1'b0)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .back_i (inject),
        .next_i (ring_hue[r+1]),
        .hue_o  (ring_hue[r])
      );
    end else begin : g_inner
      rhca_cell #(.RING_ID(r), .FAR(1'b0)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .back_i (ring_hue[r+1]),
        .next_i (ring_hue[r+1]),
        .hue_o  (ring_hue[r])
      );
    end
  end

  assign out_valid_o  = busy_q;
  assign ring_index_o = RING_IDX_W'(cnt_q);
  assign hue_top_o    = ring_hue[0][0];
  assign hue_right_o  = ring_hue[0][1];
  assign hue_bottom_o = ring_hue[0][2];
  assign hue_left_o   = ring_hue[0][3];
  assign last_ring_o  = is_last;

`ifndef SYNTHESIS
  a_first_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> cnt_q == '0)
    else $error("step run does not start at ring 0");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= CNT_W'(RINGS - 1))
    else $error("ring counter out of range");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_ring_o |=> !out_valid_o && in_ready_o)
    else $error("run does not end after last ring");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |-> !busy_q && !ctrl.rotate)
    else $error("step taken while results pending");
`endif

endmodule

FILE: hw/rtl/rhca_cell.sv
// One ring of the automaton: four face hues, step update and ring rotation.
module rhca_cell
  import rhca_pkg::*;
#(
  parameter int unsigned RING_ID = 0,
  parameter bit          FAR     = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  ring_t      back_i,
  input  ring_t      next_i,
  output ring_t      hue_o
);

  ring_t hue_q, hue_d, stepped;

  always_comb begin
    for (int unsigned f = 0; f < FACES; f++) begin
      stepped[f] = FAR ? back_i[f]
                       : cell_mix(hue_q[f], back_i[f], hue_q[(f + 3) % FACES],
                                  hue_q[(f + 1) % FACES]);
    end
  end

  always_comb begin
    hue_d = hue_q;
    if (ctrl_i.step) begin
      hue_d = stepped;
    end else if (ctrl_i.rotate) begin
      hue_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= ring_reset(RING_ID);
    end else begin
      hue_q <= hue_d;
    end
  end

  assign hue_o = hue_q;

endmodule

FILE: verif/tb.sv
// Testbench for ring_hue_cellular_automaton: random handshakes, register phases and a grid predictor.
`timescale 1ns / 100ps

module tb;
  import rhca_pkg::*;

  localparam int unsigned NUM_RINGS = 18;
  localparam int unsigned MAX_CYCLES = 800000;

  typedef struct packed {
    logic [RING_IDX_W-1:0] idx;
    hue_t                  top;
    hue_t                  right;
    hue_t                  bottom;
    hue_t                  left;
    logic                  last;
  } ring_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_STEP_PERIOD;
  hue_t cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic frame_tick_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [RING_IDX_W-1:0] ring_index_o;
  hue_t hue_top_o, hue_right_o, hue_bottom_o, hue_left_o;
  logic last_ring_o;

  ring_hue_cellular_automaton #(.RINGS(NUM_RINGS)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_tick_i (frame_tick_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ring_index_o (ring_index_o),
    .hue_top_o    (hue_top_o),
    .hue_right_o  (hue_right_o),
    .hue_bottom_o (hue_bottom_o),
    .hue_left_o   (hue_left_o),
    .last_ring_o  (last_ring_o)
  );

  logic         pending_ticks[$];
  ring_result_t ring_expect[$];

  hue_t hue_grid[FACES][NUM_RINGS];
  hue_t inject_hue;
  hue_t tick_tally;
  hue_t tick_period;
  hue_t hue_step;

  logic        drive_idle = 1'b1;
  logic        sink_idle = 1'b1;
  int unsigned tick_gap = 0;
  int unsigned ring_stall = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_wait(input logic idle_on);
    return idle_on ? $urandom_range(0, 19) : 0;
  endfunction

  task automatic reset_grid();
    for (int unsigned f = 0; f < FACES; f++) begin
      for (int unsigned r = 0; r < NUM_RINGS; r++) begin
        hue_grid[f][r] = hue_t'((f * FACE_STRIDE + r * RING_STRIDE) % 256);
      end
    end
    inject_hue = '0;
    tick_tally = '0;
    tick_period = STEP_PERIOD_RST;
    hue_step = HUE_INCREMENT_RST;
  endtask

  task automatic predict_tick(input logic tick);
    hue_t         fresh[FACES][NUM_RINGS];
    ring_result_t res;
    int unsigned  me, bk, lf, rt, mix;
    if (!tick) return;
    tick_tally = tick_tally + 8'd1;
    if (tick_tally < tick_period) return;
    tick_tally = '0;
    inject_hue = inject_hue + hue_step;
    for (int unsigned f = 0; f < FACES; f++) begin
      hue_grid[f][NUM_RINGS-1] = inject_hue + hue_t'(f * FACE_STRIDE);
    end
    for (int unsigned r = 0; r + 1 < NUM_RINGS; r++) begin
      for (int unsigned f = 0; f < FACES; f++) begin
        me = hue_grid[f][r];
        bk = hue_grid[f][r+1];
        lf = hue_grid[(f + FACES - 1) % FACES][r];
        rt = hue_grid[(f + 1) % FACES][r];
        mix = (4 * bk + 2 * me + lf + rt) / 8;
        fresh[f][r] = hue_t'((me + mix) / 2);
      end
    end
    for (int unsigned r = 0; r + 1 < NUM_RINGS; r++) begin
      for (int unsigned f = 0; f < FACES; f++) begin
        hue_grid[f][r] = fresh[f][r];
      end
    end
    for (int unsigned r = 0; r < NUM_RINGS; r++) begin
      res.idx = RING_IDX_W'(r);
      res.top = hue_grid[0][r];
      res.right = hue_grid[1][r];
      res.bottom = hue_grid[2][r];
      res.left = hue_grid[3][r];
      res.last = (r == NUM_RINGS - 1);
      ring_expect.push_back(res);
    end
  endtask

  task automatic check_ring();
    ring_result_t got, want;
    got = '{ring_index_o, hue_top_o, hue_right_o, hue_bottom_o, hue_left_o, last_ring_o};
    if (ring_expect.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("unexpected ring result: idx %0d hues %0d %0d %0d %0d last %0b",
                 got.idx, got.top, got.right, got.bottom, got.left, got.last);
      end
      return;
    end
    want = ring_expect.pop_front();
    if (got.idx !== want.idx || got.top !== want.top || got.right !== want.right ||
        got.bottom !== want.bottom || got.left !== want.left || got.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("ring mismatch: expected idx %0d hues %0d %0d %0d %0d last %0b",
                 want.idx, want.top, want.right, want.bottom, want.left, want.last);
        $display("               actual   idx %0d hues %0d %0d %0d %0d last %0b",
                 got.idx, got.top, got.right, got.bottom, got.left, got.last);
      end
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tick_gap <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (tick_gap != 0) begin
        in_valid_i <= 1'b0;
        tick_gap <= tick_gap - 1;
      end else if (pending_ticks.size() != 0) begin
        in_valid_i <= 1'b1;
        frame_tick_i <= pending_ticks.pop_front();
        tick_gap <= draw_wait(drive_idle);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) predict_tick(frame_tick_i);
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : ring_sink
    int unsigned hold;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ring_stall <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_ring();
        hold = draw_wait(sink_idle);
      end else begin
        hold = ring_stall;
      end
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        ring_stall <= hold - 1;
      end else begin
        out_ready_i <= 1'b1;
        ring_stall <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input hue_t val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_STEP_PERIOD) tick_period = val;
    else hue_step = val;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || ring_expect.size() != 0);
    repeat (NUM_RINGS + 4) @(posedge clk_i);
  endtask

  task automatic push_ticks(input int unsigned count, input int unsigned idle_pct);
    for (int unsigned i = 0; i < count; i++) begin
      pending_ticks.push_back($urandom_range(0, 99) >= idle_pct);
    end
  endtask

  initial begin
    reset_grid();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // register defaults, idle and non-stepping ticks
    pending_ticks = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    drain();

    // period zero: every tick steps
    write_reg(CFG_STEP_PERIOD, 8'd0);
    write_reg(CFG_HUE_INCREMENT, 8'hFF);
    pending_ticks = '{1'b1, 1'b0, 1'b1, 1'b1};
    drain();

    write_reg(CFG_STEP_PERIOD, 8'd1);
    write_reg(CFG_HUE_INCREMENT, 8'd0);
    pending_ticks = '{1'b1, 1'b1, 1'b0, 1'b1};
    drain();

    // lower the period below the running count
    write_reg(CFG_STEP_PERIOD, 8'd5);
    write_reg(CFG_HUE_INCREMENT, 8'd128);
    pending_ticks = '{1'b1, 1'b1, 1'b1};
    drain();
    write_reg(CFG_STEP_PERIOD, 8'd2);
    pending_ticks = '{1'b1};
    drain();

    // longest period
    write_reg(CFG_STEP_PERIOD, 8'hFF);
    write_reg(CFG_HUE_INCREMENT, 8'd1);
    drive_idle = 1'b0;
    sink_idle = 1'b0;
    repeat (30) pending_ticks.push_back(1'b1);
    drain();

    for (int unsigned ph = 0; ph < 5; ph++) begin
      write_reg(CFG_STEP_PERIOD, hue_t'($urandom_range(0, 6)));
      write_reg(CFG_HUE_INCREMENT, hue_t'($urandom_range(0, 255)));
      drive_idle = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
      push_ticks(32, 20);
      drain();
    end

    if (mismatch_count == 0 && ring_expect.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
